// File: design/peer_endpoint_learning_table_unit_assert.svh
// ----------------------------------------------------------------------------
// peer endpoint learning table assertion macros
// concurrent checks sampled on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef PEER_ENDPOINT_LEARNING_TABLE_UNIT_ASSERT_SVH
`define PEER_ENDPOINT_LEARNING_TABLE_UNIT_ASSERT_SVH

// property holds at every edge
`define PELT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define PELT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/pelt_pkg.sv
// ----------------------------------------------------------------------------
// pelt_pkg
// shared constants and types of the peer endpoint learning table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pelt_pkg;

  localparam int unsigned TABLE_DEPTH = 512;
  localparam int unsigned ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int unsigned KEY_W       = 64;
  localparam int unsigned EP_W        = 48;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned INDEX_W     = 9;

  localparam int unsigned S_TDATA_W   = ((KEY_W + EP_W + 7) / 8) * 8;
  localparam int unsigned S_PAD_W     = S_TDATA_W - (KEY_W + EP_W);
  localparam int unsigned M_FIELDS_W  = STATUS_W + 1 + INDEX_W + KEY_W + EP_W;
  localparam int unsigned M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned M_PAD_W     = M_TDATA_W - M_FIELDS_W;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t STATUS_LEARNED = 2'd0;
  localparam status_t STATUS_OK      = 2'd1;
  localparam status_t STATUS_ROAMED  = 2'd2;

  typedef struct packed {
    logic [EP_W-1:0]  endpoint;
    logic [KEY_W-1:0] key;
  } pelt_entry_t;

  localparam int unsigned ENTRY_W = $bits(pelt_entry_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } pelt_state_e;

endpackage

// File: design/peer_endpoint_learning_table_unit.sv
// ----------------------------------------------------------------------------
// peer_endpoint_learning_table_unit
// learns peer keys and tracks the endpoint each peer was last seen on
// ----------------------------------------------------------------------------
// Each input transaction carries a peer key and the endpoint it arrived from
// and gives exactly one result transaction: learned (appended at the next free
// slot, or not stored when the table is full), ok (known peer, same endpoint)
// or roamed (known peer, stored endpoint overwritten). The entries live in one
// ram with a single read port, searched linearly from slot 0, one slot per
// cycle, so a miss reads every learned entry and a hit stops at its slot;
// the table holds at most 512 entries.
// A new transaction is taken while the previous result still waits on the
// output. The ram needs no clearing after reset: only slots below the entry
// count are ever read.
`timescale 1ns / 1ps

module peer_endpoint_learning_table_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // peer_key [63:0], endpoint_addr [111:64]
  input  logic [pelt_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // status [1:0], stored [2], entry_index [11:3], peer_echo [75:12],
  // endpoint_echo [123:76], zero padding above
  output logic [pelt_pkg::M_TDATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready
);

  import pelt_pkg::*;

  `include "peer_endpoint_learning_table_unit_assert.svh"

  pelt_state_e           state_q, state_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [CNT_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic                  cmp_vld_q, cmp_vld_d;
  logic [ADDR_W-1:0]     cmp_idx_q, cmp_idx_d;
  logic                  hit_q, hit_d;
  logic                  ep_same_q, ep_same_d;
  logic [ADDR_W-1:0]     slot_q, slot_d;
  logic                  out_vld_q, out_vld_d;

  logic [KEY_W-1:0]      key_q;
  logic [EP_W-1:0]       ep_q;
  logic [M_TDATA_W-1:0]  out_data_q, out_data_d;

  logic                  in_acc;
  logic                  out_free;
  logic                  full;
  logic                  rd_en;
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  pelt_entry_t           wr_entry;
  pelt_entry_t           rd_entry;
  logic [ENTRY_W-1:0]    rd_data;
  logic                  load_out;

  status_t               res_status;
  logic                  res_stored;
  logic [ADDR_W-1:0]     res_slot;
  logic [ADDR_W+INDEX_W-1:0] res_slot_ext;
  logic [INDEX_W-1:0]    res_index;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign out_free      = !out_vld_q || m_axis_tready;
  assign full          = (cnt_q == CNT_W'(TABLE_DEPTH));
  assign rd_en         = (state_q == ST_SEARCH) && (rd_ptr_q != cnt_q);
  assign rd_entry      = pelt_entry_t'(rd_data);

  assign wr_entry.key      = key_q;
  assign wr_entry.endpoint = ep_q;

  pelt_ram #(
    .Depth (TABLE_DEPTH),
    .Width (ENTRY_W),
    .AddrW (ADDR_W)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_entry),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_ptr_q[ADDR_W-1:0]),
    .rd_data_o (rd_data)
  );

  // result of the finished search
  always_comb begin
    if (hit_q) begin
      res_status = ep_same_q ? STATUS_OK : STATUS_ROAMED;
      res_stored = 1'b1;
      res_slot   = slot_q;
    end else begin
      res_status = STATUS_LEARNED;
      res_stored = !full;
      res_slot   = full ? '0 : cnt_q[ADDR_W-1:0];
    end
    res_slot_ext = (ADDR_W + INDEX_W)'(res_slot);
    res_index    = res_slot_ext[INDEX_W-1:0];
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    rd_ptr_d   = rd_ptr_q;
    cmp_vld_d  = 1'b0;
    cmp_idx_d  = rd_ptr_q[ADDR_W-1:0];
    hit_d      = hit_q;
    ep_same_d  = ep_same_q;
    slot_d     = slot_q;
    out_vld_d  = out_vld_q;
    out_data_d = out_data_q;
    load_out   = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = hit_q ? slot_q : cnt_q[ADDR_W-1:0];

    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          rd_ptr_d = '0;
          state_d  = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmp_vld_d = rd_en;
        if (rd_en) begin
          rd_ptr_d = rd_ptr_q + 1'b1;
        end
        if (cmp_vld_q && (rd_entry.key == key_q)) begin
          hit_d     = 1'b1;
          slot_d    = cmp_idx_q;
          ep_same_d = (rd_entry.endpoint == ep_q);
          state_d   = ST_DONE;
        end else if (rd_ptr_q == cnt_q) begin
          hit_d     = 1'b0;
          ep_same_d = 1'b0;
          state_d   = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          load_out   = 1'b1;
          out_vld_d  = 1'b1;
          out_data_d = {{M_PAD_W{1'b0}}, ep_q, key_q, res_index, res_stored, res_status};
          wr_en      = hit_q ? !ep_same_q : !full;
          if (!hit_q && !full) begin
            cnt_d = cnt_q + 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      rd_ptr_q  <= '0;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      ep_same_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rd_ptr_q  <= rd_ptr_d;
      cmp_vld_q <= cmp_vld_d;
      hit_q     <= hit_d;
      ep_same_q <= ep_same_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      key_q <= s_axis_tdata[KEY_W-1:0];
      ep_q  <= s_axis_tdata[KEY_W+EP_W-1:KEY_W];
    end
    cmp_idx_q  <= cmp_idx_d;
    slot_q     <= slot_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // checks
  `PELT_ASSERT(a_cnt_range, cnt_q <= CNT_W'(TABLE_DEPTH), "entry count above table depth")
  `PELT_ASSERT(a_cnt_step, (cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + 1'b1), "entry count jumped")
  `PELT_ASSERT(a_hit_slot, (state_q == ST_DONE && hit_q) |-> (CNT_W'(slot_q) < cnt_q), "hit slot beyond learned entries")
  `PELT_ASSERT_NEXT(a_out_load, load_out, m_axis_tvalid && (state_q == ST_IDLE), "result not presented after search")

endmodule

// File: design/pelt_ram.sv
// ----------------------------------------------------------------------------
// pelt_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pelt_ram #(
  parameter int unsigned Depth = 512,
  parameter int unsigned Width = 112,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: sim/peer_table_checker.sv
// ----------------------------------------------------------------------------
// peer_table_checker
// predicts the learning table report of each packet event and compares it
// with every result transaction, field by field, in order of arrival
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module peer_table_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // peer_key [63:0], endpoint_addr [111:64]
  input  logic [pelt_pkg::S_TDATA_W-1:0] s_tdata_i,
  input  logic                           s_tvalid_i,
  input  logic                           s_tready_i,
  // status [1:0], stored [2], entry_index [11:3], peer_echo [75:12],
  // endpoint_echo [123:76], zero padding above
  input  logic [pelt_pkg::M_TDATA_W-1:0] m_tdata_i,
  input  logic                           m_tvalid_i,
  input  logic                           m_tready_i,
  output int unsigned                    mismatch_count_o,
  output int unsigned                    pending_o
);

  import pelt_pkg::*;

  typedef struct packed {
    logic [EP_W-1:0]    endpoint;
    logic [KEY_W-1:0]   peer;
    logic [INDEX_W-1:0] slot;
    logic               stored;
    status_t            status;
  } peer_report_t;

  logic [KEY_W-1:0] learned_keys [TABLE_DEPTH];
  logic [EP_W-1:0]  learned_eps  [TABLE_DEPTH];
  int unsigned      learned_count = 0;

  peer_report_t     awaited_reports [$];
  peer_report_t     exp_report;
  peer_report_t     got_report;
  logic [M_PAD_W-1:0] got_pad;
  int unsigned      bad_reports = 0;

  function automatic peer_report_t predict_report(input logic [KEY_W-1:0] key,
                                                  input logic [EP_W-1:0]  ep);
    peer_report_t r;
    int unsigned  slot;
    bit           hit;
    slot     = 0;
    hit      = 1'b0;
    r.peer     = key;
    r.endpoint = ep;
    for (int unsigned i = 0; i < learned_count; i++) begin
      if (!hit && learned_keys[i] == key) begin
        slot = i;
        hit  = 1'b1;
      end
    end
    if (!hit) begin
      r.status = STATUS_LEARNED;
      if (learned_count < TABLE_DEPTH) begin
        learned_keys[learned_count] = key;
        learned_eps[learned_count]  = ep;
        r.stored = 1'b1;
        r.slot   = INDEX_W'(learned_count);
        learned_count++;
      end else begin
        r.stored = 1'b0;
        r.slot   = '0;
      end
    end else begin
      r.stored = 1'b1;
      r.slot   = INDEX_W'(slot);
      if (learned_eps[slot] == ep) begin
        r.status = STATUS_OK;
      end else begin
        learned_eps[slot] = ep;
        r.status = STATUS_ROAMED;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_tvalid_i && m_tready_i) begin
        got_report = m_tdata_i[M_FIELDS_W-1:0];
        got_pad    = m_tdata_i[M_TDATA_W-1:M_FIELDS_W];
        if (awaited_reports.size() == 0) begin
          bad_reports++;
          if (bad_reports <= 10)
            $display("%0t ns: result transaction with nothing awaited, peer %h",
                     $time, got_report.peer);
        end else begin
          exp_report = awaited_reports.pop_front();
          if (got_report != exp_report || got_pad != '0) begin
            bad_reports++;
            if (bad_reports <= 10) begin
              $display("%0t ns: result mismatch, expected status %0d stored %0d slot %0d",
                       $time, exp_report.status, exp_report.stored, exp_report.slot);
              $display("  expected peer %h endpoint %h",
                       exp_report.peer, exp_report.endpoint);
              $display("  got status %0d stored %0d slot %0d padding %h",
                       got_report.status, got_report.stored, got_report.slot, got_pad);
              $display("  got peer %h endpoint %h",
                       got_report.peer, got_report.endpoint);
            end
          end
        end
      end
      if (s_tvalid_i && s_tready_i)
        awaited_reports.push_back(predict_report(s_tdata_i[KEY_W-1:0],
                                                 s_tdata_i[KEY_W+EP_W-1:KEY_W]));
    end
    mismatch_count_o <= bad_reports;
    pending_o        <= awaited_reports.size();
  end

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// packet event stimulus for the peer endpoint learning table
// ----------------------------------------------------------------------------
// Directed events on the extreme keys and endpoints, then random phases of
// new peers, repeats, roams and near-miss keys under varied idling, until
// the table is full and overflowing. The checker predicts and compares.
`timescale 1ns / 1ps

module tb_top;

  import pelt_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 2_500_000;
  localparam int unsigned DRAIN_CYCLES = 600;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned PHASE_ITEMS  = 145;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned IDLE_PCT     = 55;
  localparam int unsigned BOTH_PCT     = 11;

  logic                 clk           = 1'b0;
  logic                 rst_n         = 1'b0;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;

  int unsigned mismatch_count;
  int unsigned pending;
  int unsigned cycle_count        = 0;
  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned hold_requests      = 0;
  int unsigned hold_taken         = 0;
  int unsigned hold_left          = 0;

  // peers the table should hold, in slot order, with their last endpoint
  logic [KEY_W-1:0] table_peers [$];
  logic [EP_W-1:0]  table_eps   [$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  peer_endpoint_learning_table_unit dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  peer_table_checker checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .s_tdata_i        (s_axis_tdata),
    .s_tvalid_i       (s_axis_tvalid),
    .s_tready_i       (s_axis_tready),
    .m_tdata_i        (m_axis_tdata),
    .m_tvalid_i       (m_axis_tvalid),
    .m_tready_i       (m_axis_tready),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("[peer_endpoint_learning_table_unit] ERROR");
      $finish;
    end
  end

  // result side: long hold-off on request, random stalls otherwise
  always @(negedge clk) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_taken != hold_requests) begin
      hold_taken    <= hold_requests;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_n && ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  function automatic logic [KEY_W-1:0] random_key();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [EP_W-1:0] random_endpoint();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[EP_W-1:0];
  endfunction

  task automatic offer_event(input logic [KEY_W-1:0] key, input logic [EP_W-1:0] ep);
    int found;
    found = -1;
    foreach (table_peers[i])
      if (found < 0 && table_peers[i] == key) found = i;
    if (found >= 0) begin
      table_eps[found] = ep;
    end else if (table_peers.size() < TABLE_DEPTH) begin
      table_peers.push_back(key);
      table_eps.push_back(ep);
    end
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tdata  <= {ep, key};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic random_event();
    logic [KEY_W-1:0] key;
    logic [EP_W-1:0]  ep;
    int unsigned      pick;
    int unsigned      idx;
    int unsigned      bit_pos;
    pick = $urandom_range(0, 99);
    ep   = random_endpoint();
    if (table_peers.size() == 0 || pick < 45) begin
      key = random_key();
    end else begin
      idx = $urandom_range(0, table_peers.size() - 1);
      key = table_peers[idx];
      if (pick < 50) begin
        // near miss: one key bit away from a learned peer
        bit_pos      = $urandom_range(0, KEY_W - 1);
        key[bit_pos] = ~key[bit_pos];
      end else if (pick < 75) begin
        ep = table_eps[idx];
      end else if (pick < 88) begin
        bit_pos     = $urandom_range(0, EP_W - 1);
        ep          = table_eps[idx];
        ep[bit_pos] = ~ep[bit_pos];
      end
    end
    offer_event(key, ep);
  endtask

  task automatic pause_until_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  initial begin
    logic [KEY_W-1:0] last_peer;
    logic [EP_W-1:0]  last_ep;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // extremes, ok, roam and near-miss keys
    offer_event('0, '0);
    offer_event('1, '1);
    offer_event('0, '0);
    offer_event('0, '1);
    offer_event('1, '0);
    offer_event({32{2'b01}}, {24{2'b10}});
    offer_event({32{2'b10}}, {24{2'b01}});
    offer_event(64'hFFFF_FFFF_FFFF_FFFE, '1);
    offer_event(64'h7FFF_FFFF_FFFF_FFFF, '0);
    offer_event({32{2'b10}}, {24{2'b01}});
    offer_event('1, 48'h8000_0000_0000);
    offer_event('1, 48'h8000_0000_0001);
    offer_event(64'h8000_0000_0000_0000, 48'h0000_0000_0001);
    offer_event(64'h0000_0000_0000_0001, 48'h8000_0000_0000);
    pause_until_drained();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
          hold_requests++;
        end
        1: begin
          sender_idle_pct    = IDLE_PCT;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = IDLE_PCT;
        end
        default: begin
          sender_idle_pct    = BOTH_PCT;
          receiver_stall_pct = BOTH_PCT;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) random_event();
      pause_until_drained();
    end

    // top up to a full table, then hit the last slot and overflow it
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    while (table_peers.size() < TABLE_DEPTH) offer_event(random_key(), random_endpoint());
    last_peer = table_peers[TABLE_DEPTH-1];
    last_ep   = table_eps[TABLE_DEPTH-1];
    offer_event(last_peer, last_ep);
    offer_event(last_peer, ~last_ep);
    offer_event(~last_peer, '0);
    offer_event(random_key(), '1);
    pause_until_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0 && pending == 0) begin
      $display("[peer_endpoint_learning_table_unit] OK");
    end else begin
      $display("[peer_endpoint_learning_table_unit] ERROR");
    end
    $finish;
  end

endmodule
